>>> rtl/core/prtd_pkg.sv
package prtd_pkg;

	localparam int COLOR_W   = 16;
	localparam int RUN_W     = 5;
	localparam int GROUP_W   = 64;
	localparam int NUM_GROUPS = 4;
	localparam int CFG_IDX_W = 2;
	localparam int BYTES_W   = 9;
	localparam logic [BYTES_W-1:0] BYTES_MAX = 9'd256;
	localparam logic [RUN_W-1:0] RUN_FULL = 5'd16;

	typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] palette_t;

	// one decoded byte waiting for expansion
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [RUN_W-1:0]   run;
	} prtd_cmd_t;

	function automatic logic [COLOR_W-1:0] palette_color(input palette_t pal,
			input logic [3:0] idx);
		logic [GROUP_W-1:0] word;
		logic [5:0]         lsb;
		word = pal[idx[3:2]];
		lsb  = {idx[1:0], 4'b0000};
		return word[lsb +: COLOR_W];
	endfunction

	// high nibble is the run, zero stands for a full run of sixteen
	function automatic logic [RUN_W-1:0] run_length(input logic [3:0] nib);
		return (nib == 4'd0) ? RUN_FULL : {1'b0, nib};
	endfunction

endpackage

>>> rtl/core/prtd_front.sv
module prtd_front
	import prtd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rle_byte,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GROUP_W-1:0]   cfg_data,
	output logic                 push_valid,
	input  logic                 push_ready,
	output prtd_cmd_t            push_cmd
);

	palette_t pal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q <= '0;
		end else if (cfg_valid) begin
			pal_q[cfg_index] <= cfg_data;
		end
	end

	assign in_ready       = push_ready;
	assign push_valid     = in_valid;
	assign push_cmd.color = palette_color(pal_q, rle_byte[3:0]);
	assign push_cmd.run   = run_length(rle_byte[7:4]);

endmodule

>>> rtl/core/prtd_fifo.sv
module prtd_fifo
	import prtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  prtd_cmd_t push_cmd,
	output logic      pop_valid,
	input  logic      pop_ready,
	output prtd_cmd_t pop_cmd
);

	prtd_cmd_t  mem_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> rtl/core/prtd_back.sv
module prtd_back
	import prtd_pkg::*;
#(
	parameter int TILE_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  prtd_cmd_t          pop_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] pixel_color,
	output logic [7:0]         pixel_position,
	output logic               run_end,
	output logic               tile_end,
	output logic [BYTES_W-1:0] tile_bytes
);

	localparam int PW  = $clog2(TILE_SIZE);
	localparam int PXW = (PW > 8) ? PW : 8;
	localparam logic [PW-1:0] LAST_POS = PW'(TILE_SIZE - 1);

	logic               active_q;
	logic [RUN_W-1:0]   run_left_q;
	logic [COLOR_W-1:0] color_q;
	logic [PW-1:0]      pos_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               out_valid_q;
	logic [COLOR_W-1:0] color_o_q;
	logic [7:0]         pos_o_q;
	logic               run_end_q;
	logic               tile_end_q;
	logic [BYTES_W-1:0] tile_bytes_q;

	logic               can_emit;
	logic               emit;
	logic [RUN_W-1:0]   run_cur;
	logic [COLOR_W-1:0] color_cur;
	logic [BYTES_W-1:0] bytes_cur;
	logic               last_tile;
	logic               last_run;
	logic [PXW-1:0]     pos_ext;

	assign can_emit  = !out_valid_q || out_ready;
	assign emit      = can_emit && (active_q || pop_valid);
	assign pop_ready = can_emit && !active_q;

	// first pixel of a byte comes straight from the queue head
	assign run_cur   = active_q ? run_left_q : pop_cmd.run;
	assign color_cur = active_q ? color_q : pop_cmd.color;
	assign bytes_cur = (active_q || bytes_q == BYTES_MAX) ? bytes_q
		: bytes_q + BYTES_W'(1);
	assign last_tile = (pos_q >= LAST_POS);
	assign last_run  = (run_cur == RUN_W'(1)) || last_tile;
	assign pos_ext   = PXW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_q       <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_emit) out_valid_q <= emit;
			if (emit) begin
				active_q <= !last_run;
				if (last_tile) begin
					pos_q   <= '0;
					bytes_q <= '0;
				end else begin
					pos_q   <= pos_q + PW'(1);
					bytes_q <= bytes_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			run_left_q   <= run_cur - RUN_W'(1);
			color_q      <= color_cur;
			color_o_q    <= color_cur;
			pos_o_q      <= pos_ext[7:0];
			run_end_q    <= last_run;
			tile_end_q   <= last_tile;
			tile_bytes_q <= last_tile ? bytes_cur : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_color    = color_o_q;
	assign pixel_position = pos_o_q;
	assign run_end        = run_end_q;
	assign tile_end       = tile_end_q;
	assign tile_bytes     = tile_bytes_q;

endmodule

>>> rtl/core/palette_rle_tile_decoder.sv
// path: a byte accepted is written into the queue; the back end takes its first pixel
// from the queue head into the registered output
// throughput: one pixel per cycle from the expansion counter while out_ready does not stall;
// a byte with run n gives n pixels (1 to 16, fewer when the tile ends inside the run); the
// input side runs ahead by up to two bytes in the queue
// reset: arst_n clears the palette, tile position, byte count, queue and output valid
module palette_rle_tile_decoder
	import prtd_pkg::*;
#(
	parameter int TILE_SIZE = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rle_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GROUP_W-1:0]   cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COLOR_W-1:0]   pixel_color,
	output logic [7:0]           pixel_position,
	output logic                 run_end,
	output logic                 tile_end,
	output logic [BYTES_W-1:0]   tile_bytes
);

	logic      push_valid;
	logic      push_ready;
	prtd_cmd_t push_cmd;
	logic      pop_valid;
	logic      pop_ready;
	prtd_cmd_t pop_cmd;

	assign cfg_ready = 1'b1;

	prtd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rle_byte   (rle_byte),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	prtd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	prtd_back #(
		.TILE_SIZE (TILE_SIZE)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_cmd        (pop_cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_color    (pixel_color),
		.pixel_position (pixel_position),
		.run_end        (run_end),
		.tile_end       (tile_end),
		.tile_bytes     (tile_bytes)
	);

endmodule

>>> rtl/core/prtd_checker.sv
module prtd_checker
	import prtd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COLOR_W-1:0]   pixel_color,
	input logic [7:0]           pixel_position,
	input logic                 run_end,
	input logic                 tile_end,
	input logic [BYTES_W-1:0]   tile_bytes
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color)
			&& $stable(pixel_position) && $stable(tile_end))
		else $error("stalled pixel changed");

	a_tile_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tile_end |-> run_end)
		else $error("tile end without run end");

	a_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tile_end |-> tile_bytes == '0)
		else $error("byte count shown off tile end");

	a_bytes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tile_end |-> tile_bytes != '0 && tile_bytes <= BYTES_MAX)
		else $error("bad tile byte count");

	// position restarts after a tile end
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && tile_end ##1 out_valid |-> pixel_position == 8'd0)
		else $error("position not cleared after tile end");

endmodule

bind palette_rle_tile_decoder prtd_checker u_prtd_checker (.*);

>>> sim/rle_pixel_checker.sv
`timescale 1ns / 1ps

module rle_pixel_checker
	import prtd_pkg::*;
#(
	parameter int TILE_SIZE = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           rle_byte,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GROUP_W-1:0]   cfg_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [COLOR_W-1:0]   pixel_color,
	input  logic [7:0]           pixel_position,
	input  logic                 run_end,
	input  logic                 tile_end,
	input  logic [BYTES_W-1:0]   tile_bytes,
	output int                   pending,
	output int                   errors,
	output int                   pixel_count,
	output int                   tile_count
);

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [7:0]         position;
		logic               run_end;
		logic               tile_end;
		logic [BYTES_W-1:0] tile_bytes;
	} pixel_t;

	pixel_t             expected_pixels[$];
	pixel_t             head;
	logic [GROUP_W-1:0] palette [NUM_GROUPS];
	int unsigned        tile_pos;
	logic [BYTES_W-1:0] tile_byte_cnt;
	int                 err_cnt;
	int                 pix_cnt;
	int                 tiles_done;

	// one byte expands into its run of pixels, cut at the tile boundary
	task automatic expand_byte(input logic [7:0] b);
		logic [GROUP_W-1:0] word;
		logic [COLOR_W-1:0] color;
		int unsigned        run;
		pixel_t             px;
		word  = palette[b[3:2]];
		color = COLOR_W'(word >> (b[1:0] * COLOR_W));
		run   = (b[7:4] == 4'd0) ? 16 : b[7:4];
		if (tile_byte_cnt != BYTES_MAX)
			tile_byte_cnt++;
		for (int k = 0; k < run; k++) begin
			px.color      = color;
			px.position   = tile_pos[7:0];
			px.tile_end   = (tile_pos >= TILE_SIZE - 1);
			px.run_end    = (k == run - 1) || px.tile_end;
			px.tile_bytes = px.tile_end ? tile_byte_cnt : '0;
			expected_pixels.push_back(px);
			if (px.tile_end) begin
				tile_pos      = 0;
				tile_byte_cnt = '0;
				break;
			end
			tile_pos++;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_pixels.delete();
			for (int g = 0; g < NUM_GROUPS; g++)
				palette[g] = '0;
			tile_pos      = 0;
			tile_byte_cnt = '0;
			err_cnt       = 0;
			pix_cnt       = 0;
			tiles_done    = 0;
			pending     <= 0;
			errors      <= 0;
			pixel_count <= 0;
			tile_count  <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				palette[cfg_index] = cfg_data;
			// output first: a pixel leaving now never belongs to a byte entering now
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel with none expected: color %0h position %0d",
						pixel_color, pixel_position);
					err_cnt++;
				end else begin
					head = expected_pixels.pop_front();
					check_field("pixel_color", head.color, pixel_color);
					check_field("pixel_position", 16'(head.position),
						16'(pixel_position));
					check_field("run_end", 16'(head.run_end), 16'(run_end));
					check_field("tile_end", 16'(head.tile_end), 16'(tile_end));
					check_field("tile_bytes", 16'(head.tile_bytes), 16'(tile_bytes));
					pix_cnt++;
					if (head.tile_end)
						tiles_done++;
				end
			end
			if (in_valid && in_ready)
				expand_byte(rle_byte);
			pending     <= expected_pixels.size();
			errors      <= err_cnt;
			pixel_count <= pix_cnt;
			tile_count  <= tiles_done;
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import prtd_pkg::*;

	localparam int TILE_SIZE   = 256;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rle_byte;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GROUP_W-1:0]   cfg_data;
	logic                 out_valid;
	logic                 out_ready;
	logic [COLOR_W-1:0]   pixel_color;
	logic [7:0]           pixel_position;
	logic                 run_end;
	logic                 tile_end;
	logic [BYTES_W-1:0]   tile_bytes;

	int pending;
	int errors;
	int pixel_count;
	int tile_count;
	int cycle_cnt;
	int bytes_sent;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_request;

	palette_rle_tile_decoder #(
		.TILE_SIZE(TILE_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rle_byte(rle_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_color(pixel_color),
		.pixel_position(pixel_position),
		.run_end(run_end),
		.tile_end(tile_end),
		.tile_bytes(tile_bytes)
	);

	rle_pixel_checker #(
		.TILE_SIZE(TILE_SIZE)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rle_byte(rle_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_color(pixel_color),
		.pixel_position(pixel_position),
		.run_end(run_end),
		.tile_end(tile_end),
		.tile_bytes(tile_bytes),
		.pending(pending),
		.errors(errors),
		.pixel_count(pixel_count),
		.tile_count(tile_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still expected", cycle_cnt, pending);
			$display("Verification failed");
			$finish;
		end
	end

	// pixel sink: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_request != 0) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			rle_byte <= 8'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rle_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_random(input int count);
		logic [7:0] b;
		int         sel;
		for (int n = 0; n < count; n++) begin
			b   = 8'($urandom);
			sel = $urandom_range(9);
			// bias toward single pixels, full runs and runs of fifteen
			if (sel < 2)
				b[7:4] = 4'h1;
			else if (sel == 2)
				b[7:4] = 4'h0;
			else if (sel == 3)
				b[7:4] = 4'hF;
			send_byte(b);
		end
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_palette(input logic [GROUP_W-1:0] groups [NUM_GROUPS]);
		for (int g = 0; g < NUM_GROUPS; g++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(g);
			cfg_data  <= groups[g];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [GROUP_W-1:0] groups [NUM_GROUPS];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		rle_byte     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		bytes_sent   = 0;
		hold_request = 0;
		tx_idle_pct  = 23;
		rx_idle_pct  = 52;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int g = 0; g < NUM_GROUPS; g++)
			groups[g] = {$urandom, $urandom};
		load_palette(groups);

		// every index with every run length, then full runs up to a cut at the tile end
		for (int i = 0; i < 16; i++)
			send_byte({4'(i) ^ 4'h5, 4'(i)});
		for (int i = 0; i < 7; i++)
			send_byte({4'h0, 4'(i)});
		send_byte(8'h0F);
		send_byte(8'hFF);
		send_random(90);
		drain_pixels();

		tx_idle_pct = 52;
		rx_idle_pct = 23;
		for (int g = 0; g < NUM_GROUPS; g++)
			groups[g] = '1;
		load_palette(groups);
		send_random(80);
		drain_pixels();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int g = 0; g < NUM_GROUPS; g++)
			groups[g] = {$urandom, $urandom};
		load_palette(groups);
		hold_request = 1;
		send_random(60);
		drain_pixels();
		send_random(40);
		drain_pixels();

		for (int g = 0; g < NUM_GROUPS; g++)
			groups[g] = '0;
		load_palette(groups);
		send_random(36);
		drain_pixels();
		repeat (20) @(posedge clk);

		$display("sent %0d bytes, checked %0d pixels across %0d completed tiles",
			bytes_sent, pixel_count, tile_count);
		$display("random, all-ones and all-zero palettes; stalls both sides, %0d-cycle sink hold",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/prtd_pkg.sv
rtl/core/prtd_front.sv
rtl/core/prtd_fifo.sv
rtl/core/prtd_back.sv
rtl/core/palette_rle_tile_decoder.sv
rtl/core/prtd_checker.sv
sim/rle_pixel_checker.sv
sim/testbench.sv
